// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
// Implication with a non-overlapping consequent, checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`endif

// ===== rtl/sppq_pkg.sv =====
// Package with constants, types and helpers for the sprite pixel palette quantizer.
`timescale 1ns / 1ps
package sppq_pkg;
	localparam int PaletteCountDef = 4;
	localparam int BlinkEntriesDef = 16;
	localparam int NormalSlots = 3;
	localparam logic [1:0] ACT_CONVERT = 2'd0;
	localparam logic [1:0] ACT_BLINK_WR = 2'd1;
	localparam logic [1:0] ACT_NORMAL_WR = 2'd2;
	localparam logic [0:0] REG_BACKGROUND = 1'b0;
	localparam logic [0:0] REG_BLINK_EN = 1'b1;

	typedef logic [17:0] dist_t;

	// Squared distance over the three low bytes of two colours.
	function automatic dist_t color_dist(input logic [31:0] a, input logic [31:0] b);
		logic signed [8:0] d0, d1, d2;
		logic [17:0] p0, p1, p2;
		begin
			d0 = $signed({1'b0, a[7:0]}) - $signed({1'b0, b[7:0]});
			d1 = $signed({1'b0, a[15:8]}) - $signed({1'b0, b[15:8]});
			d2 = $signed({1'b0, a[23:16]}) - $signed({1'b0, b[23:16]});
			p0 = 18'(d0 * d0);
			p1 = 18'(d1 * d1);
			p2 = 18'(d2 * d2);
			color_dist = p0 + p1 + p2;
		end
	endfunction
endpackage

// ===== rtl/sprite_pixel_palette_quantizer.sv =====
// Top level of the sprite pixel palette quantizer.
`timescale 1ns / 1ps
// Streaming pixel quantizer taking one transfer per cycle. A pixel passes
// five register stages: table read, per-entry distance and match, a first
// minimum reduction over groups of four entries, the final minimum with the
// index choice, and the code formation with its output register. A stall at
// the output holds every stage. Table writes take effect on acceptance and
// give no result; the tables are held in flip-flops and read in parallel so
// every entry is compared at once.
module sprite_pixel_palette_quantizer #(
	parameter int PALETTE_COUNT = sppq_pkg::PaletteCountDef,
	parameter int BLINK_ENTRIES = sppq_pkg::BlinkEntriesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] pixel_color,
	input  logic        inside_req,
	input  logic        odd_row,
	input  logic [1:0]  palette_select,
	input  logic        nearest_mode,
	input  logic [3:0]  entry_slot,
	input  logic [31:0] entry_color,
	input  logic        entry_enable,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  main_code,
	output logic [1:0]  blink_code,
	output logic        assigned
);
	import sppq_pkg::*;
	localparam int NE = BLINK_ENTRIES;
	localparam int IW = (NE > 1) ? $clog2(NE) : 1;
	localparam int PW = (PALETTE_COUNT > 1) ? $clog2(PALETTE_COUNT) : 1;
	localparam int SW = $clog2(NormalSlots);
	localparam int NC = NE + NormalSlots;
	localparam int NG = (NE + 3) / 4;
	localparam int NP = 4 * NG;

	logic [31:0] bg_q;
	logic        blink_en_q;
	logic [31:0] bcol_q [NE][PALETTE_COUNT];
	logic        bon_q  [NE][PALETTE_COUNT];
	logic [31:0] ncol_q [NormalSlots][PALETTE_COUNT];

	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_BACKGROUND: prdata = bg_q;
			REG_BLINK_EN:   prdata = {31'd0, blink_en_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= '0;
			blink_en_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_BACKGROUND) bg_q <= pwdata;
			else blink_en_q <= pwdata[0];
		end
	end

	logic acc;
	assign acc = in_valid && adv;
	logic pal_ok;
	assign pal_ok = 32'(palette_select) < PALETTE_COUNT;
	logic [PW-1:0] pidx;
	assign pidx = PW'(palette_select);

	// Table writes.
	always_ff @(posedge clk) begin
		if (acc && pal_ok) begin
			if (action == ACT_BLINK_WR && 32'(entry_slot) < NE) begin
				bcol_q[IW'(entry_slot)][pidx] <= entry_color;
				bon_q[IW'(entry_slot)][pidx] <= entry_enable;
			end
			if (action == ACT_NORMAL_WR && entry_slot >= 4'd1 && entry_slot <= 4'd3)
				ncol_q[SW'(entry_slot - 4'd1)][pidx] <= entry_color;
		end
	end

	// Stage 1: read the selected palette.
	logic        v_s1, cv_s1, odd_s1, near_s1, blk_s1;
	logic [31:0] pix_s1;
	logic [31:0] ec_s1 [NC];
	logic        eo_s1 [NC];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= acc && action == ACT_CONVERT;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cv_s1 <= inside_req && pixel_color != bg_q && pal_ok;
			odd_s1 <= odd_row;
			near_s1 <= nearest_mode;
			blk_s1 <= blink_en_q;
			pix_s1 <= pixel_color;
			for (int i = 0; i < NE; i++) begin
				ec_s1[i] <= pal_ok ? bcol_q[i][pidx] : '0;
				eo_s1[i] <= pal_ok ? bon_q[i][pidx] : 1'b0;
			end
			for (int c = 0; c < NormalSlots; c++) begin
				ec_s1[NE+c] <= pal_ok ? ncol_q[c][pidx] : '0;
				eo_s1[NE+c] <= 1'b1;
			end
		end
	end

	// Stage 2: per-entry match and distance.
	logic        v_s2, cv_s2, odd_s2, near_s2, blk_s2;
	logic        hit_s2 [NC];
	logic        on_s2  [NP];
	dist_t       d_s2   [NC];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			{cv_s2, odd_s2, near_s2, blk_s2} <= {cv_s1, odd_s1, near_s1, blk_s1};
			for (int i = 0; i < NC; i++) begin
				hit_s2[i] <= eo_s1[i] && ec_s1[i] == pix_s1;
				d_s2[i] <= color_dist(pix_s1, ec_s1[i]);
			end
			// Padding entries of the last group never compete.
			for (int i = 0; i < NP; i++)
				on_s2[i] <= (i < NE) && eo_s1[i];
		end
	end

	// Stage 3: first match, normal palette choice and the least distance
	// within each group of four blink entries.
	logic          fh_c;
	logic [IW-1:0] hi_c;
	logic [1:0]    nh_c, nn_c;
	logic          nhit_c;
	logic          gon_c [NG];
	dist_t         gd_c  [NG];
	logic [IW-1:0] gi_c  [NG];
	always_comb begin
		fh_c = 1'b0; hi_c = '0;
		for (int i = NE - 1; i >= 0; i--)
			if (hit_s2[i]) begin fh_c = 1'b1; hi_c = IW'(i); end
		nhit_c = 1'b1;
		priority if (hit_s2[NE]) nh_c = 2'd1;
		else if (hit_s2[NE+1]) nh_c = 2'd2;
		else if (hit_s2[NE+2]) nh_c = 2'd3;
		else begin nh_c = 2'd0; nhit_c = 1'b0; end
		nn_c = 2'd1;
		if (d_s2[NE+1] < d_s2[NE]) nn_c = 2'd2;
		if (d_s2[NE+2] < ((d_s2[NE+1] < d_s2[NE]) ? d_s2[NE+1] : d_s2[NE])) nn_c = 2'd3;
	end
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			gon_c[g] = 1'b0;
			gd_c[g] = '0;
			gi_c[g] = '0;
			for (int k = 0; k < 4; k++)
				if (on_s2[4*g+k] && (!gon_c[g] || d_s2[4*g+k] < gd_c[g])) begin
					gon_c[g] = 1'b1;
					gd_c[g] = d_s2[4*g+k];
					gi_c[g] = IW'(4*g + k);
				end
		end
	end

	logic          v_s3, cv_s3, odd_s3, near_s3, blk_s3;
	logic          fh_s3, nf_s3;
	logic [IW-1:0] hi_s3;
	logic [1:0]    nc_s3;
	logic          gon_s3 [NG];
	dist_t         gd_s3  [NG];
	logic [IW-1:0] gi_s3  [NG];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			{cv_s3, odd_s3, near_s3, blk_s3} <= {cv_s2, odd_s2, near_s2, blk_s2};
			fh_s3 <= fh_c;
			hi_s3 <= hi_c;
			nf_s3 <= nhit_c || near_s2;
			nc_s3 <= nhit_c ? nh_c : nn_c;
			for (int g = 0; g < NG; g++) begin
				gon_s3[g] <= gon_c[g];
				gd_s3[g] <= gd_c[g];
				gi_s3[g] <= gi_c[g];
			end
		end
	end

	// Stage 4: least distance over the groups and the index choice. Lower
	// groups hold lower indices, so a strict compare keeps the lowest on ties.
	logic          fn_c;
	logic [IW-1:0] ni_c;
	dist_t         best_c;
	always_comb begin
		fn_c = 1'b0; ni_c = '0; best_c = '0;
		for (int g = 0; g < NG; g++)
			if (gon_s3[g] && (!fn_c || gd_s3[g] < best_c)) begin
				fn_c = 1'b1; best_c = gd_s3[g]; ni_c = gi_s3[g];
			end
	end

	logic          v_s4, found_s4;
	logic [3:0]    idx_s4;
	logic          blk_s4, odd_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s4 <= blk_s3;
			odd_s4 <= odd_s3;
			if (!cv_s3) begin
				found_s4 <= 1'b0; idx_s4 <= '0;
			end else if (blk_s3) begin
				found_s4 <= fh_s3 || (near_s3 && fn_c);
				idx_s4 <= 4'(fh_s3 ? hi_s3 : ni_c);
			end else begin
				found_s4 <= nf_s3;
				idx_s4 <= {2'd0, nc_s3};
			end
		end
	end

	// Stage 5: split the index into codes, output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			assigned <= found_s4;
			if (!found_s4) begin
				main_code <= '0; blink_code <= '0;
			end else if (!blk_s4) begin
				main_code <= idx_s4[1:0]; blink_code <= '0;
			end else if (odd_s4) begin
				main_code <= idx_s4[1:0]; blink_code <= idx_s4[3:2];
			end else begin
				main_code <= idx_s4[3:2]; blink_code <= idx_s4[1:0];
			end
		end
	end
endmodule

// ===== rtl/sppq_checker.sv =====
// Port-level checker for the sprite pixel palette quantizer, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sppq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] main_code,
	input logic [1:0] blink_code,
	input logic       assigned
);
	`CHK_IMPL(a_unassigned_zero, clk, arst_n, out_valid && !assigned, main_code == 2'd0 && blink_code == 2'd0)
	`CHK_IMPL(a_stall_back, clk, arst_n, out_valid && out_stall, in_stall)
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(main_code))
endmodule

bind sprite_pixel_palette_quantizer sppq_checker u_sppq_checker (.*);
